>>> rtl/tangent_steer_avoidance_defines.svh
// Assertion macros for the tangent steer avoidance block.
`ifndef TANGENT_STEER_AVOIDANCE_DEFINES_SVH
`define TANGENT_STEER_AVOIDANCE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TSA_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TSA_ASSERT(label, clk, rst_n, prop, msg)
`define TSA_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> rtl/tsa_pkg.sv
// Shared constants, widths and the arctangent table of the tangent steer block.
package tsa_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;

    localparam int VW = 32;  // vectoring x/y width
    localparam int RW = 34;  // rotating x/y width
    localparam int ZW = 25;  // angle width, deg/32768

    localparam logic signed [17:0] DEG90  = 18'sd11520;
    localparam logic signed [17:0] DEG180 = 18'sd23040;
    localparam logic signed [18:0] DEG360 = 19'sd46080;
    localparam logic signed [ZW-1:0] Z_QUARTER = 25'sd2949120;
    localparam logic signed [ZW-1:0] Z_HALF    = 25'sd5898240;
    localparam logic signed [30:0]   GAIN_INV  = 31'sd652032874;

    localparam logic [1:0] REG_INSIDE_RADIUS = 2'd0;
    localparam logic [1:0] REG_CRUISE_SPEED  = 2'd1;

    // byte addresses of the registers on the APB port
    localparam logic [2:0] ADDR_INSIDE_RADIUS = 3'd0;
    localparam logic [2:0] ADDR_CRUISE_SPEED  = 3'd4;

    // atan(2^-i) in deg*32768
    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        case (i)
            0:  atan_tab = 25'sd1474560;
            1:  atan_tab = 25'sd870484;
            2:  atan_tab = 25'sd459940;
            3:  atan_tab = 25'sd233473;
            4:  atan_tab = 25'sd117189;
            5:  atan_tab = 25'sd58652;
            6:  atan_tab = 25'sd29333;
            7:  atan_tab = 25'sd14667;
            8:  atan_tab = 25'sd7334;
            9:  atan_tab = 25'sd3667;
            10: atan_tab = 25'sd1833;
            11: atan_tab = 25'sd917;
            12: atan_tab = 25'sd458;
            13: atan_tab = 25'sd229;
            14: atan_tab = 25'sd115;
            15: atan_tab = 25'sd57;
            16: atan_tab = 25'sd29;
            17: atan_tab = 25'sd14;
            18: atan_tab = 25'sd7;
            19: atan_tab = 25'sd4;
            20: atan_tab = 25'sd2;
            21: atan_tab = 25'sd1;
            default: atan_tab = 25'sd0;
        endcase
    endfunction
endpackage

>>> rtl/tangent_steer_avoidance.sv
// Top level of the tangent steer avoidance pipeline.
//
// Usage: sensor requests enter on the s_ stream (tdata carries vehicle and goal
// positions, obstacle distance and bearing); one result per request leaves on
// the m_ stream (avoid flag, heading, east and north velocity).
// The APB port sets inside_radius (address 0) and cruise_speed (address 4);
// write it only while the pipeline is empty.
// Depth: 2*CORDIC_STEPS+8 = 40 register stages.
// Throughput: one request per cycle while the receiver does not stall; the
// goal bearing vectoring CORDIC and the velocity rotating CORDIC each take
// one stage per iteration, and the gain correction multiply is split over
// two stages.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults (inside_radius 1024, cruise_speed 819).
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
`include "tangent_steer_avoidance_defines.svh"
module tangent_steer_avoidance import tsa_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // pos_x[19:0], pos_y[39:20], goal_x[59:40], goal_y[79:60],
    // obstacle_distance[95:80], obstacle_bearing[111:96]
    input  logic [111:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // avoid_active[0], heading[16:1], vel_x[32:17], vel_y[48:33], zero[55:49]
    output logic [55:0]  o_m_tdata,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);
    localparam int NS = CORDIC_STEPS;

    logic [15:0] r_inside_radius;
    logic [14:0] r_cruise_speed;
    logic        en;

    // configuration registers
    assign o_pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_radius <= 16'd1024;
            r_cruise_speed  <= 15'd819;
        end else if (i_psel && i_penable && i_pwrite && o_pready) begin
            unique case (i_paddr)
                ADDR_INSIDE_RADIUS: r_inside_radius <= i_pwdata[15:0];
                ADDR_CRUISE_SPEED:  r_cruise_speed  <= i_pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = 32'd0;
        unique case (i_paddr)
            ADDR_INSIDE_RADIUS: o_prdata = {16'd0, r_inside_radius};
            ADDR_CRUISE_SPEED:  o_prdata = {17'd0, r_cruise_speed};
            default: ;
        endcase
    end

    // global advance: move when the output is free or being taken
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // stage 1: differences and threshold
    logic               r1_v, r1_act;
    logic signed [20:0] r1_dx, r1_dy;
    logic signed [15:0] r1_brg;

    // stage 2 and vectoring stages
    logic                  rv_v    [NS+1];
    logic                  rv_act  [NS+1];
    logic signed [15:0]    rv_brg  [NS+1];
    logic                  rv_spec [NS+1];
    logic signed [15:0]    rv_sval [NS+1];
    logic signed [VW-1:0]  rv_x    [NS+1];
    logic signed [VW-1:0]  rv_y    [NS+1];
    logic signed [ZW-1:0]  rv_z    [NS+1];

    // stage 3: goal bearing
    logic               r3_v, r3_act;
    logic signed [15:0] r3_brg, r3_tgt;
    // stage 4: heading
    logic               r4_v, r4_act;
    logic signed [15:0] r4_hdg;

    // rotation init and rotating stages
    logic                 rr_v    [NS+1];
    logic                 rr_act  [NS+1];
    logic signed [15:0]   rr_hdg  [NS+1];
    logic                 rr_flip [NS+1];
    logic signed [RW-1:0] rr_x    [NS+1];
    logic signed [RW-1:0] rr_y    [NS+1];
    logic signed [ZW-1:0] rr_z    [NS+1];

    // stage 6: partial products, stage 7: scaled values
    logic               r6_v, r6_act, r6_flip;
    logic signed [15:0] r6_hdg;
    logic signed [47:0] r6_pxh, r6_pyh, r6_pxl, r6_pyl;
    logic               r7_v, r7_act;
    logic signed [15:0] r7_hdg;
    logic signed [19:0] r7_x, r7_y;

    logic               r_o_v, r_o_act;
    logic signed [15:0] r_o_hdg, r_o_vx, r_o_vy;

    // combinational helpers
    logic signed [20:0] n1_dx, n1_dy;
    logic signed [VW-1:0] n2_x, n2_y, n2_x0, n2_y0;
    logic signed [ZW-1:0] n2_z;
    logic                 n2_spec;
    logic signed [15:0]   n2_sval;
    logic signed [25:0]   n3_r;
    logic signed [17:0]   n3_q;
    logic signed [17:0]   n4_lo, n4_hi, n4_t;
    logic signed [18:0]   n4_d0, n4_d1;
    logic signed [ZW-1:0] n5_z0, n5_z;
    logic                 n5_flip;
    logic signed [63:0]   n7_sx, n7_sy;
    logic signed [19:0]   n7_x, n7_y;
    logic signed [15:0]   n8_vx, n8_vy;

    assign n1_dx = 21'(signed'(i_s_tdata[59:40])) - 21'(signed'(i_s_tdata[19:0]));
    assign n1_dy = 21'(signed'(i_s_tdata[79:60])) - 21'(signed'(i_s_tdata[39:20]));

    // pre-rotate into the right half plane, flag axis cases
    always_comb begin
        n2_x0   = VW'(r1_dx) <<< 8;
        n2_y0   = VW'(r1_dy) <<< 8;
        n2_x    = n2_x0;
        n2_y    = n2_y0;
        n2_z    = '0;
        n2_spec = 1'b1;
        n2_sval = 16'sd0;
        if (r1_dx == 0 && r1_dy == 0)
            n2_sval = 16'sd0;
        else if (r1_dy == 0)
            n2_sval = (r1_dx > 0) ? 16'sd0 : 16'(DEG180);
        else if (r1_dx == 0)
            n2_sval = (r1_dy > 0) ? 16'(DEG90) : -16'(DEG90);
        else
            n2_spec = 1'b0;
        if (n2_x0 < 0) begin
            if (n2_y0 > 0) begin
                n2_x = n2_y0;
                n2_y = -n2_x0;
                n2_z = Z_QUARTER;
            end else begin
                n2_x = -n2_y0;
                n2_y = n2_x0;
                n2_z = -Z_QUARTER;
            end
        end
    end

    // goal bearing rounding and clamp
    always_comb begin
        n3_r = (26'(rv_z[NS]) + 26'sd128) >>> 8;
        n3_q = 18'(n3_r);
        if (n3_r > 26'(DEG180))
            n3_q = DEG180;
        else if (n3_r < -26'(DEG180))
            n3_q = -DEG180;
    end

    // tangent choice with folded differences, then wrap
    always_comb begin
        n4_lo = 18'(r3_brg) - DEG90;
        n4_hi = 18'(r3_brg) + DEG90;
        n4_d0 = 19'(r3_tgt) - 19'(n4_lo);
        n4_d1 = 19'(r3_tgt) - 19'(n4_hi);
        if (n4_d0 < 0) n4_d0 = -n4_d0;
        if (n4_d1 < 0) n4_d1 = -n4_d1;
        if (n4_d0 > 19'(DEG180)) n4_d0 = DEG360 - n4_d0;
        if (n4_d1 > 19'(DEG180)) n4_d1 = DEG360 - n4_d1;
        n4_t = (n4_d0 > n4_d1) ? n4_hi : n4_lo;
        if (n4_t > DEG180)
            n4_t = 18'(19'(n4_t) - DEG360);
        else if (n4_t < -DEG180)
            n4_t = 18'(19'(n4_t) + DEG360);
    end

    // fold heading into +-90 degrees
    always_comb begin
        n5_z0   = ZW'(r4_hdg) <<< 8;
        n5_z    = n5_z0;
        n5_flip = 1'b0;
        if (n5_z0 > Z_QUARTER) begin
            n5_z    = n5_z0 - Z_HALF;
            n5_flip = 1'b1;
        end else if (n5_z0 < -Z_QUARTER) begin
            n5_z    = n5_z0 + Z_HALF;
            n5_flip = 1'b1;
        end
    end

    // gain correction sum and rounding
    always_comb begin
        n7_sx = (64'(r6_pxh) <<< 17) + 64'(r6_pxl) + (64'sd1 <<< 45);
        n7_sy = (64'(r6_pyh) <<< 17) + 64'(r6_pyl) + (64'sd1 <<< 45);
        n7_x  = 20'(n7_sx >>> 46);
        n7_y  = 20'(n7_sy >>> 46);
        if (r6_flip) begin
            n7_x = -n7_x;
            n7_y = -n7_y;
        end
    end

    // saturate to +-32767
    always_comb begin
        n8_vx = r7_x[15:0];
        n8_vy = r7_y[15:0];
        if (r7_x > 20'sd32767) n8_vx = 16'sd32767;
        else if (r7_x < -20'sd32767) n8_vx = -16'sd32767;
        if (r7_y > 20'sd32767) n8_vy = 16'sd32767;
        else if (r7_y < -20'sd32767) n8_vy = -16'sd32767;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r_o_v <= 1'b0;
            for (int k = 0; k <= NS; k++) begin
                rv_v[k] <= 1'b0;
                rr_v[k] <= 1'b0;
            end
        end else if (en) begin
            r1_v    <= i_s_tvalid;
            rv_v[0] <= r1_v;
            for (int k = 0; k < NS; k++) begin
                rv_v[k+1] <= rv_v[k];
                rr_v[k+1] <= rr_v[k];
            end
            r3_v    <= rv_v[NS];
            r4_v    <= r3_v;
            rr_v[0] <= r4_v;
            r6_v    <= rr_v[NS];
            r7_v    <= r6_v;
            r_o_v   <= r7_v;
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx  <= n1_dx;
            r1_dy  <= n1_dy;
            r1_brg <= signed'(i_s_tdata[111:96]);
            r1_act <= i_s_tdata[95:80] < r_inside_radius;

            rv_act[0]  <= r1_act;
            rv_brg[0]  <= r1_brg;
            rv_spec[0] <= n2_spec;
            rv_sval[0] <= n2_sval;
            rv_x[0]    <= n2_x;
            rv_y[0]    <= n2_y;
            rv_z[0]    <= n2_z;
            for (int k = 0; k < NS; k++) begin
                rv_act[k+1]  <= rv_act[k];
                rv_brg[k+1]  <= rv_brg[k];
                rv_spec[k+1] <= rv_spec[k];
                rv_sval[k+1] <= rv_sval[k];
                if (rv_y[k] >= 0) begin
                    rv_x[k+1] <= rv_x[k] + (rv_y[k] >>> k);
                    rv_y[k+1] <= rv_y[k] - (rv_x[k] >>> k);
                    rv_z[k+1] <= rv_z[k] + atan_tab(k);
                end else begin
                    rv_x[k+1] <= rv_x[k] - (rv_y[k] >>> k);
                    rv_y[k+1] <= rv_y[k] + (rv_x[k] >>> k);
                    rv_z[k+1] <= rv_z[k] - atan_tab(k);
                end
            end

            r3_act <= rv_act[NS];
            r3_brg <= rv_brg[NS];
            r3_tgt <= rv_spec[NS] ? rv_sval[NS] : 16'(n3_q);

            r4_act <= r3_act;
            r4_hdg <= r3_act ? 16'(n4_t) : r3_tgt;

            rr_act[0]  <= r4_act;
            rr_hdg[0]  <= r4_hdg;
            rr_flip[0] <= n5_flip;
            rr_z[0]    <= n5_z;
            rr_x[0]    <= RW'({1'b0, r_cruise_speed}) <<< 16;
            rr_y[0]    <= '0;
            for (int k = 0; k < NS; k++) begin
                rr_act[k+1]  <= rr_act[k];
                rr_hdg[k+1]  <= rr_hdg[k];
                rr_flip[k+1] <= rr_flip[k];
                if (rr_z[k] >= 0) begin
                    rr_x[k+1] <= rr_x[k] - (rr_y[k] >>> k);
                    rr_y[k+1] <= rr_y[k] + (rr_x[k] >>> k);
                    rr_z[k+1] <= rr_z[k] - atan_tab(k);
                end else begin
                    rr_x[k+1] <= rr_x[k] + (rr_y[k] >>> k);
                    rr_y[k+1] <= rr_y[k] - (rr_x[k] >>> k);
                    rr_z[k+1] <= rr_z[k] + atan_tab(k);
                end
            end

            r6_act  <= rr_act[NS];
            r6_hdg  <= rr_hdg[NS];
            r6_flip <= rr_flip[NS];
            r6_pxh  <= 48'(signed'(rr_x[NS][RW-1:17]) * GAIN_INV);
            r6_pyh  <= 48'(signed'(rr_y[NS][RW-1:17]) * GAIN_INV);
            r6_pxl  <= 48'(signed'({1'b0, rr_x[NS][16:0]}) * GAIN_INV);
            r6_pyl  <= 48'(signed'({1'b0, rr_y[NS][16:0]}) * GAIN_INV);

            r7_act <= r6_act;
            r7_hdg <= r6_hdg;
            r7_x   <= n7_x;
            r7_y   <= n7_y;

            r_o_act <= r7_act;
            r_o_hdg <= r7_hdg;
            r_o_vx  <= n8_vx;
            r_o_vy  <= n8_vy;
        end
    end

    assign o_m_tvalid = r_o_v;
    assign o_m_tdata  = {7'd0, r_o_vy, r_o_vx, r_o_hdg, r_o_act};

    // checks
    `TSA_ASSERT(a_ready_rule, i_clk, i_rst_n, o_s_tready == (!r_o_v || i_m_tready), "ready rule broken")
    `TSA_ASSERT(a_vel_sat, i_clk, i_rst_n, r_o_v |-> (r_o_vx != 16'h8000 && r_o_vy != 16'h8000), "velocity not saturated")
    `TSA_ASSERT(a_hold, i_clk, i_rst_n, (r_o_v && !i_m_tready) |=> (r_o_v && $stable(r_o_hdg)), "result lost in stall")
    `TSA_ASSERT_RST(a_reset, i_clk, !i_rst_n |=> !r_o_v, "valid after reset")
endmodule

>>> dv/testbench.sv
// Self-checking testbench for the tangent steer avoidance pipeline.
module testbench import tsa_pkg::*;;

    localparam int LAT      = 2 * CORDIC_STEPS + 8;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] heading;
        logic               avoid;
    } steer_t;

    typedef struct {
        logic signed [19:0] px, py, gx, gy;
        logic [15:0]        obs_dist;
        logic signed [15:0] brg;
    } sensor_t;

    // directed row: stimulus plus optional typed-in expectation
    typedef struct {
        sensor_t s;
        bit      has_exp;
        steer_t  e;
    } row_t;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic [111:0] i_s_tdata = '0;
    logic         i_m_tready = 0;
    logic         i_psel = 0, i_penable = 0, i_pwrite = 0;
    logic [2:0]   i_paddr = '0;
    logic [31:0]  i_pwdata = '0;
    wire          o_s_tready, o_m_tvalid, o_pready;
    wire  [55:0]  o_m_tdata;
    wire  [31:0]  o_prdata;

    tangent_steer_avoidance u_dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    int unsigned radius_q = 1024, speed_q = 819;
    steer_t steer_q[$];
    int errors = 0, n_sent = 0, n_recv = 0, n_avoid = 0;
    int idle_cycles = 0;
    bit  sink_idle_ok = 1, sink_hold = 0;

    function automatic longint asr64(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint atan_lut(int i);
        longint tab[24] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
            14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0};
        return tab[i];
    endfunction

    // bearing from vehicle to goal, deg/128
    function automatic longint bearing_to_goal(longint dx, longint dy);
        longint x, y, z, t, xs, ys;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        if (dy == 0) return dx > 0 ? 0 : 23040;
        if (dx == 0) return dy > 0 ? 11520 : -11520;
        x = dx * 256;
        y = dy * 256;
        if (x < 0) begin
            t = x;
            if (y > 0) begin
                x = y; y = -t; z = Z_QUARTER;
            end else begin
                x = -y; y = t; z = -Z_QUARTER;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
            xs = asr64(x, i);
            ys = asr64(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += atan_lut(i);
            end else begin
                x = x - ys; y = y + xs; z -= atan_lut(i);
            end
        end
        return clip(asr64(z + 128, 8), -23040, 23040);
    endfunction

    function automatic steer_t steer_predict(sensor_t s);
        steer_t r;
        longint tgt, lo, hi, d0, d1, tan_h, hdg, z, x, y, xs, ys;
        bit active, flip;
        active = s.obs_dist < radius_q;
        tgt = bearing_to_goal(longint'(s.gx) - s.px, longint'(s.gy) - s.py);
        lo = longint'(s.brg) - 11520;
        hi = longint'(s.brg) + 11520;
        d0 = tgt - lo;
        d1 = tgt - hi;
        if (d0 < 0) d0 = -d0;
        if (d1 < 0) d1 = -d1;
        if (d0 > 23040) d0 = 46080 - d0;
        if (d1 > 23040) d1 = 46080 - d1;
        tan_h = (d0 > d1) ? hi : lo;
        if (tan_h > 23040) tan_h -= 46080;
        else if (tan_h < -23040) tan_h += 46080;
        hdg = active ? tan_h : tgt;
        // rotate the speed vector to the heading
        z = hdg * 256;
        x = longint'(speed_q) * 65536;
        y = 0;
        flip = 0;
        if (z > Z_QUARTER) begin
            z -= Z_HALF; flip = 1;
        end else if (z < -Z_QUARTER) begin
            z += Z_HALF; flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
            xs = asr64(x, i);
            ys = asr64(y, i);
            if (z >= 0) begin
                x = x - ys; y = y + xs; z -= atan_lut(i);
            end else begin
                x = x + ys; y = y - xs; z += atan_lut(i);
            end
        end
        x = asr64(x * 652032874 + (longint'(1) << 45), 46);
        y = asr64(y * 652032874 + (longint'(1) << 45), 46);
        if (flip) begin
            x = -x; y = -y;
        end
        r.avoid = active;
        r.heading = hdg[15:0];
        r.vel_x = 16'(clip(x, -32767, 32767));
        r.vel_y = 16'(clip(y, -32767, 32767));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_recv);
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        steer_t g, w;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("watchdog expired");
                $display("TB_ERROR");
                $finish;
            end
            if (o_m_tvalid && i_m_tready) begin
                g = o_m_tdata[48:0];
                n_recv++;
                if (o_m_tdata[55:49] != 0) report_mismatch("pad", o_m_tdata[55:49], 0);
                if (steer_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    w = steer_q.pop_front();
                    if (g.avoid != w.avoid) report_mismatch("avoid", g.avoid, w.avoid);
                    if (g.heading != w.heading) report_mismatch("heading", g.heading, w.heading);
                    if (g.vel_x != w.vel_x) report_mismatch("vel_x", g.vel_x, w.vel_x);
                    if (g.vel_y != w.vel_y) report_mismatch("vel_y", g.vel_y, w.vel_y);
                end
            end
        end
    end

    // receiver: random stall bursts, or a long hold when asked
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (sink_hold) begin
                i_m_tready <= 0;
                repeat (300) @(posedge i_clk);
                sink_hold = 0;
            end else if (sink_idle_ok && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 6);
                i_m_tready <= 0;
                repeat (n) @(posedge i_clk);
            end else begin
                i_m_tready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        i_psel <= 1; i_penable <= 0; i_pwrite <= 1;
        i_paddr <= {idx, 1'b0} << 1; i_pwdata <= val;
        @(posedge i_clk);
        i_penable <= 1;
        @(posedge i_clk iff o_pready);
        i_psel <= 0; i_penable <= 0; i_pwrite <= 0;
        if (idx == REG_INSIDE_RADIUS) radius_q = val[15:0];
        else if (idx == REG_CRUISE_SPEED) speed_q = val[14:0];
    endtask

    // hold until every expected result has come, then let the pipe drain
    task automatic drain_pipe();
        while (steer_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic send_request(sensor_t s, bit gaps);
        int n;
        if (gaps && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 6);
            i_s_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= {s.brg, s.obs_dist, s.gy, s.gx, s.py, s.px};
        @(posedge i_clk iff o_s_tready);
        steer_q.push_back(steer_predict(s));
        n_sent++;
        if (s.obs_dist < radius_q) n_avoid++;
    endtask

    function automatic sensor_t rand_sensor(int mode);
        sensor_t s;
        s.px = 20'($urandom); s.py = 20'($urandom);
        s.gx = 20'($urandom); s.gy = 20'($urandom);
        s.obs_dist = 16'($urandom);
        s.brg = 16'($urandom_range(0, 46080) - 23040);
        case (mode)
            0: begin  // near goal, near obstacle
                s.gx = s.px + $signed(12'($urandom));
                s.gy = s.py + $signed(12'($urandom));
                s.obs_dist = 16'($urandom_range(0, 2 * radius_q + 1));
            end
            1: s.brg = 16'($urandom);     // bearing outside range too
            2: s.gy = s.py;               // goal on an axis
            3: s.gx = s.px;
            default: ;
        endcase
        return s;
    endfunction

    initial begin
        row_t rows[$];
        row_t r;
        int unsigned radii[4] = '{0, 65535, 1024, 30000};
        int unsigned speeds[4] = '{16384, 0, 32767, 819};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed rows: goal at vehicle, axes, extremes, bearing edge cases
        r.has_exp = 0;
        r.s = '{0, 0, 0, 0, 65535, 0};
        r.has_exp = 1; r.e = '{0, 819, 0, 0}; rows.push_back(r);      // goal at vehicle
        r.s = '{0, 0, 100, 0, 2000, 0}; rows.push_back(r);             // east axis
        r.has_exp = 0;
        r.s = '{0, 0, -100, 0, 2000, 0}; rows.push_back(r);
        r.s = '{0, 0, 0, 100, 2000, 0}; rows.push_back(r);
        r.s = '{0, 0, 0, -100, 2000, 0}; rows.push_back(r);
        r.s = '{-524288, -524288, 524287, 524287, 0, 23040}; rows.push_back(r);
        r.s = '{524287, 524287, -524288, -524288, 1023, -23040}; rows.push_back(r);
        r.s = '{524287, -524288, -524288, 524287, 1024, 0}; rows.push_back(r);
        r.s = '{0, 0, 5, 3, 0, 32767}; rows.push_back(r);
        r.s = '{0, 0, -5, 3, 0, -32768}; rows.push_back(r);
        r.s = '{0, 0, -5, -3, 0, 11520}; rows.push_back(r);
        r.s = '{0, 0, 5, -3, 0, -11520}; rows.push_back(r);
        r.s = '{0, 0, -100, 0, 10, 0}; rows.push_back(r);              // tie on the diff
        r.s = '{0, 0, 100, 1, 10, 23040}; rows.push_back(r);
        r.s = '{1, 2, 3, 4, 10, -23039}; rows.push_back(r);
        foreach (rows[i]) begin
            send_request(rows[i].s, 0);
            if (rows[i].has_exp) steer_q[$] = rows[i].e;
        end
        i_s_tvalid <= 0;
        drain_pipe();

        // random phases over several register settings
        for (int ph = 0; ph < 4; ph++) begin
            reg_write(REG_INSIDE_RADIUS, radii[ph]);
            reg_write(REG_CRUISE_SPEED, speeds[ph]);
            if (ph == 1) sink_hold = 1;
            for (int k = 0; k < 300; k++) begin
                if (ph == 3 && k > 220) sink_idle_ok = 0;
                send_request(rand_sensor($urandom_range(0, 5)), sink_idle_ok);
            end
            i_s_tvalid <= 0;
            drain_pipe();
        end

        $display("sent %0d requests over 5 register settings, %0d with avoidance", n_sent,
                 n_avoid);
        $display("received %0d results", n_recv);
        if (errors == 0 && steer_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
